@@ rtl/a8x_pkg.sv @@
// Package of the ARMv8 subset executor: sizes, opcodes, result type and states.
// Used by every module of the block.
package a8x_pkg;

    localparam int unsigned A8X_DATA_WORDS = 1024;
    localparam int unsigned A8X_REG_COUNT  = 32;
    localparam int unsigned A8X_REG_AW     = $clog2(A8X_REG_COUNT);
    localparam logic [63:0] A8X_START_PC   = 64'h0000_0000_0040_0000;
    localparam logic [4:0]  A8X_ZERO_REG   = 5'd31;

    localparam logic [31:0] HLT_WORD = 32'hD440_0000;

    // Register-register group, bits 31:21.
    localparam logic [10:0] OP_ADD   = 11'h458;
    localparam logic [10:0] OP_ADDX  = 11'h459;
    localparam logic [10:0] OP_ADDS  = 11'h558;
    localparam logic [10:0] OP_ADDSX = 11'h559;
    localparam logic [10:0] OP_AND   = 11'h450;
    localparam logic [10:0] OP_ANDS  = 11'h750;
    localparam logic [10:0] OP_EOR   = 11'h650;
    localparam logic [10:0] OP_ORR   = 11'h550;
    localparam logic [10:0] OP_SUB   = 11'h658;
    localparam logic [10:0] OP_SUBX  = 11'h659;
    localparam logic [10:0] OP_SUBS  = 11'h758;
    localparam logic [10:0] OP_SUBSX = 11'h759;
    localparam logic [10:0] OP_MUL   = 11'h4D8;
    localparam logic [10:0] OP_BR    = 11'h6B0;

    // Load and store group, bits 31:21.
    localparam logic [10:0] OP_STUR   = 11'h7C0;
    localparam logic [10:0] OP_STURH  = 11'h3C0;
    localparam logic [10:0] OP_STURB  = 11'h1C0;
    localparam logic [10:0] OP_LDUR   = 11'h7C2;
    localparam logic [10:0] OP_LDURH  = 11'h3C2;
    localparam logic [10:0] OP_LDURB  = 11'h1C2;

    // Immediate group, bits 31:22, and MOVZ, bits 31:23.
    localparam logic [9:0] OP_ADDI  = 10'h244;
    localparam logic [9:0] OP_ADDIS = 10'h2C4;
    localparam logic [9:0] OP_SUBI  = 10'h344;
    localparam logic [9:0] OP_SUBIS = 10'h3C4;
    localparam logic [9:0] OP_SHIFT = 10'h34D;
    localparam logic [8:0] OP_MOVZ  = 9'h1A5;

    // Branch group.
    localparam logic [5:0] OP_B     = 6'h05;
    localparam logic [6:0] OP_BRGRP = 7'h6B;
    localparam logic [7:0] OP_CBZ   = 8'hB4;
    localparam logic [7:0] OP_CBNZ  = 8'hB5;
    localparam logic [7:0] OP_BCOND = 8'h54;

    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_GE = 4'hA;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_GT = 4'hC;
    localparam logic [3:0] COND_LE = 4'hD;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MUL  = 5'b00100,
        S_MEM  = 5'b01000,
        S_WR2  = 5'b10000
    } t_state;

    typedef struct packed {
        logic [63:0]        next_pc;
        logic               halted;
        logic               unrecognized;
        logic               reg_written;
        logic [4:0]         written_reg;
        logic signed [63:0] written_value;
        logic               flag_neg;
        logic               flag_zero;
    } t_result;

endpackage

@@ rtl/a8x_if.sv @@
// Valid/ready channel interfaces of the executor: instruction in, result out.
interface a8x_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface a8x_out_if;
    logic               valid;
    logic               ready;
    logic [63:0]        next_pc;
    logic               halted;
    logic               unrecognized;
    logic               reg_written;
    logic [4:0]         written_reg;
    logic signed [63:0] written_value;
    logic               flag_neg;
    logic               flag_zero;

    modport source (output valid, output next_pc, output halted, output unrecognized,
                    output reg_written, output written_reg, output written_value,
                    output flag_neg, output flag_zero, input ready);
    modport sink   (input valid, input next_pc, input halted, input unrecognized,
                    input reg_written, input written_reg, input written_value,
                    input flag_neg, input flag_zero, output ready);
endinterface

@@ rtl/a8x_regfile.sv @@
// General register file: a two-read, one-write synchronous memory with valid bits
// and write-to-read forwarding. Depends on a8x_pkg.
module a8x_regfile
    import a8x_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [A8X_REG_AW-1:0] i_ra_addr,
    input  logic [A8X_REG_AW-1:0] i_rb_addr,
    input  logic                  i_we,
    input  logic [A8X_REG_AW-1:0] i_waddr,
    input  logic [63:0]           i_wdata,
    output logic [63:0]           o_a,
    output logic [63:0]           o_b
);

    logic [63:0]              r_mem [A8X_REG_COUNT];
    logic [A8X_REG_COUNT-1:0] r_valid;
    logic [63:0]              r_qa, r_qb, r_ova, r_ovb;
    logic                     r_usea, r_useb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_qa <= r_mem[i_ra_addr];
            r_qb <= r_mem[i_rb_addr];
        end
    end

    // An entry never written, the zero register, or one written in the same
    // cycle is served from the override path instead of the array.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_usea  <= 1'b0;
            r_useb  <= 1'b0;
            r_ova   <= '0;
            r_ovb   <= '0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_usea <= 1'b0;
                r_useb <= 1'b0;
                if (i_ra_addr == A8X_ZERO_REG) begin
                    r_ova <= '0;
                end else if (i_we && i_waddr == i_ra_addr) begin
                    r_ova <= i_wdata;
                end else if (!r_valid[i_ra_addr]) begin
                    r_ova <= '0;
                end else begin
                    r_usea <= 1'b1;
                end
                if (i_rb_addr == A8X_ZERO_REG) begin
                    r_ovb <= '0;
                end else if (i_we && i_waddr == i_rb_addr) begin
                    r_ovb <= i_wdata;
                end else if (!r_valid[i_rb_addr]) begin
                    r_ovb <= '0;
                end else begin
                    r_useb <= 1'b1;
                end
            end
        end
    end

    assign o_a = r_usea ? r_qa : r_ova;
    assign o_b = r_useb ? r_qb : r_ovb;

endmodule

@@ rtl/a8x_dmem.sv @@
// Data memory: word array with two read ports, one write port and a clearing
// pass after reset. Depends on a8x_pkg.
module a8x_dmem
    import a8x_pkg::*;
#(
    parameter int unsigned DATA_WORDS = A8X_DATA_WORDS,
    localparam int unsigned AW        = $clog2(DATA_WORDS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output logic          o_busy,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_ra0,
    input  logic [AW-1:0] i_ra1,
    output logic [31:0]   o_q0,
    output logic [31:0]   o_q1,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [31:0]   i_wd
);

    logic [31:0]   r_mem [DATA_WORDS];
    logic          r_clearing;
    logic [AW-1:0] r_clr_idx;
    logic [AW-1:0] c_wa;
    logic [31:0]   c_wd;
    logic          c_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(DATA_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        c_we = r_clearing || i_we;
        c_wa = r_clearing ? r_clr_idx : i_wa;
        c_wd = r_clearing ? 32'd0 : i_wd;
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem[c_wa] <= c_wd;
        end
        if (i_rd_en) begin
            o_q0 <= r_mem[i_ra0];
            o_q1 <= r_mem[i_ra1];
        end
    end

    assign o_busy = r_clearing;

endmodule

@@ rtl/armv8_subset_instruction_executor_unit.sv @@
// Top level of the ARMv8 subset executor: sequencer, execute logic, result register.
// Depends on a8x_pkg, a8x_if, a8x_regfile and a8x_dmem.

// The block takes one 32-bit instruction word per transfer on i_in, executes it
// against its own PC, register file, N/Z flags and data memory, and returns one
// result per instruction on o_out. An ALU, move, shift or branch instruction
// reads the register file in the cycle of the input transfer and executes and
// writes back in S_EXEC, in which the following instruction can already be
// taken, so a stream of them runs at one instruction per cycle while o_out is
// not stalled. MUL passes through S_MUL as well (the 64-bit product is built
// from 32-bit partial products), loads and halfword/byte stores through S_MEM
// for the data memory read, and a 64-bit store through S_MEM and S_WR2 for its
// two word writes. The result waits in an output register; a new instruction is
// taken while a finished one is still being transferred out. After reset the
// data memory is cleared one word per cycle and i_in is not ready until that is
// done; writes of start_pc on i_cfg_we are taken at any time and load the PC at
// once. DATA_WORDS must be a power of two.
module armv8_subset_instruction_executor_unit
    import a8x_pkg::*;
#(
    parameter int unsigned DATA_WORDS = A8X_DATA_WORDS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [63:0]      i_cfg_wdata,
    a8x_in_if.sink           i_in,
    a8x_out_if.source        o_out
);

    localparam int unsigned AW = $clog2(DATA_WORDS);

    t_state        r_state, n_state;
    logic [31:0]   r_ins;
    logic [63:0]   r_pc, n_pc;
    logic          r_n, n_n, r_z, n_z, r_halt, n_halt;
    logic [AW-1:0] r_i0, n_i0, r_i1, n_i1;
    logic [63:0]   r_pp0, n_pp0;
    logic          r_out_valid, n_out_valid;
    t_result       r_res, n_res;

    logic          c_accept, c_out_free, c_done, c_busy;
    logic [63:0]   c_a, c_b;
    logic          c_rf_we;
    logic [63:0]   c_val, c_npc, c_addr;
    logic          c_wr, c_setf, c_err;
    logic          c_dm_rd, c_dm_we;
    logic [AW-1:0] c_dm_wa;
    logic [31:0]   c_dm_wd, c_q0, c_q1;
    logic [31:0]   c_cross;

    // Fields of the instruction being executed.
    logic [2:0]  c_grp, c_lgrp;
    logic [10:0] c_op11;
    logic [4:0]  c_rd;
    logic [11:0] c_imm12;
    logic        c_is_mem, c_is_mul, c_is_load, c_cond;

    assign c_grp   = r_ins[28:26];
    assign c_lgrp  = r_ins[27:25];
    assign c_op11  = r_ins[31:21];
    assign c_rd    = r_ins[4:0];
    assign c_imm12 = r_ins[21:10];

    assign c_out_free = !r_out_valid || o_out.ready;
    assign c_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = !c_busy && (r_state == S_IDLE || c_done);

    // Port B reads Rm for register-register forms and Rt/Rd otherwise.
    a8x_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (c_accept),
        .i_ra_addr (i_in.instruction[9:5]),
        .i_rb_addr (i_in.instruction[27:25] == 3'd5 ? i_in.instruction[20:16]
                                                    : i_in.instruction[4:0]),
        .i_we      (c_rf_we),
        .i_waddr   (c_rd),
        .i_wdata   (c_val),
        .o_a       (c_a),
        .o_b       (c_b)
    );

    a8x_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (c_busy),
        .i_rd_en (c_dm_rd),
        .i_ra0   (c_addr[AW+1:2]),
        .i_ra1   (c_addr[AW+1:2] + 1'b1),
        .o_q0    (c_q0),
        .o_q1    (c_q1),
        .i_we    (c_dm_we),
        .i_wa    (c_dm_wa),
        .i_wd    (c_dm_wd)
    );

    // Classification of the held instruction into the multi-cycle kinds.
    always_comb begin
        c_is_mem  = 1'b0;
        c_is_load = 1'b0;
        if (r_ins != HLT_WORD && c_grp != 3'd5 && c_grp != 3'd4 &&
            c_grp[2:1] != 2'd0 && c_lgrp != 3'd7 && c_lgrp != 3'd5) begin
            c_is_mem  = c_op11 == OP_STUR || c_op11 == OP_STURH || c_op11 == OP_STURB ||
                        c_op11 == OP_LDUR || c_op11 == OP_LDURH || c_op11 == OP_LDURB;
            c_is_load = c_op11 == OP_LDUR || c_op11 == OP_LDURH || c_op11 == OP_LDURB;
        end
        c_is_mul = r_ins != HLT_WORD && c_grp[2:1] != 2'd0 && c_grp != 3'd4 &&
                   c_grp != 3'd5 && c_lgrp == 3'd5 && c_op11 == OP_MUL;
        case (r_ins[3:0])
            COND_EQ: c_cond = r_z;
            COND_NE: c_cond = !r_z;
            COND_GE: c_cond = !r_n;
            COND_LT: c_cond = r_n;
            COND_GT: c_cond = !r_z && !r_n;
            COND_LE: c_cond = r_z || r_n;
            default: c_cond = 1'b0;
        endcase
    end

    assign c_addr  = c_a + {{55{r_ins[20]}}, r_ins[20:12]};
    assign c_cross = c_a[31:0] * c_b[63:32] + c_a[63:32] * c_b[31:0];

    // Execute: the value, flags and next PC of the held instruction, and the
    // sequencing of memory and multiply steps.
    always_comb begin
        c_val   = '0;
        c_wr    = 1'b0;
        c_setf  = 1'b0;
        c_err   = 1'b0;
        c_npc   = r_pc + 64'd4;
        c_done  = 1'b0;
        c_dm_rd = 1'b0;
        c_dm_we = 1'b0;
        c_dm_wa = r_i0;
        c_dm_wd = c_b[31:0];
        n_state = r_state;
        n_i0    = r_i0;
        n_i1    = r_i1;
        n_pp0   = r_pp0;
        case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_EXEC: begin
                if (!r_halt && c_is_mem) begin
                    c_dm_rd = 1'b1;
                    n_i0    = c_addr[AW+1:2];
                    n_i1    = c_addr[AW+1:2] + 1'b1;
                    n_state = S_MEM;
                end else if (!r_halt && c_is_mul) begin
                    n_pp0   = c_a[31:0] * c_b[31:0];
                    n_state = S_MUL;
                end else begin
                    c_done = c_out_free;
                    if (r_ins == HLT_WORD) begin
                        c_npc = r_pc + 64'd4;
                    end else if (c_grp == 3'd5) begin
                        if (r_ins[31:26] == OP_B) begin
                            c_npc = r_pc + {{36{r_ins[25]}}, r_ins[25:0], 2'b00};
                        end else if (r_ins[31:25] == OP_BRGRP) begin
                            if (c_op11 == OP_BR) begin
                                c_npc = c_a;
                            end
                        end else if ((r_ins[31:24] == OP_CBNZ && c_b != 64'd0) ||
                                     (r_ins[31:24] == OP_CBZ && c_b == 64'd0) ||
                                     (r_ins[31:24] == OP_BCOND && c_cond)) begin
                            c_npc = r_pc + {{43{r_ins[23]}}, r_ins[23:5], 2'b00};
                        end
                    end else if (c_grp == 3'd4) begin
                        if (r_ins[31:23] == OP_MOVZ) begin
                            c_val = {48'd0, r_ins[20:5]} << {r_ins[22:21], 4'd0};
                            c_wr  = 1'b1;
                        end else if (r_ins[31:22] == OP_ADDI || r_ins[31:22] == OP_ADDIS) begin
                            c_val  = c_a + {52'd0, c_imm12};
                            c_wr   = 1'b1;
                            c_setf = r_ins[31:22] == OP_ADDIS;
                        end else if (r_ins[31:22] == OP_SUBI || r_ins[31:22] == OP_SUBIS) begin
                            c_val  = c_a - {52'd0, c_imm12};
                            c_wr   = 1'b1;
                            c_setf = r_ins[31:22] == OP_SUBIS;
                        end else if (r_ins[31:22] == OP_SHIFT) begin
                            c_wr  = 1'b1;
                            c_val = (c_imm12[5:0] == 6'h3F) ? c_a >> c_imm12[11:6]
                                                            : c_a << (6'd0 - c_imm12[11:6]);
                        end
                    end else if (c_grp[2:1] == 2'd0 || c_lgrp == 3'd7) begin
                        c_err = 1'b1;
                    end else if (c_lgrp == 3'd5) begin
                        case (c_op11)
                            OP_ADD, OP_ADDX:   begin c_val = c_a + c_b; c_wr = 1'b1; end
                            OP_ADDS, OP_ADDSX: begin
                                c_val = c_a + c_b; c_wr = 1'b1; c_setf = 1'b1;
                            end
                            OP_AND:            begin c_val = c_a & c_b; c_wr = 1'b1; end
                            OP_ANDS:           begin
                                c_val = c_a & c_b; c_wr = 1'b1; c_setf = 1'b1;
                            end
                            OP_EOR:            begin c_val = c_a ^ c_b; c_wr = 1'b1; end
                            OP_ORR:            begin c_val = c_a | c_b; c_wr = 1'b1; end
                            OP_SUB, OP_SUBX:   begin c_val = c_a - c_b; c_wr = 1'b1; end
                            OP_SUBS, OP_SUBSX: begin
                                c_val = c_a - c_b; c_wr = 1'b1; c_setf = 1'b1;
                            end
                            OP_BR:             c_npc = c_a;
                            default:           c_wr = 1'b0;
                        endcase
                    end
                end
            end
            S_MUL: begin
                c_done = c_out_free;
                c_val  = r_pp0 + {c_cross, 32'd0};
                c_wr   = 1'b1;
            end
            S_MEM: begin
                if (c_is_load) begin
                    c_done = c_out_free;
                    c_wr   = 1'b1;
                    case (c_op11)
                        OP_LDUR:  c_val = {c_q1, c_q0};
                        OP_LDURH: c_val = {48'd0, c_q0[15:0]};
                        default:  c_val = {56'd0, c_q0[7:0]};
                    endcase
                end else if (c_op11 == OP_STUR) begin
                    c_dm_we = 1'b1;
                    n_state = S_WR2;
                end else begin
                    c_done  = c_out_free;
                    c_dm_we = c_out_free;
                    c_dm_wd = (c_op11 == OP_STURH) ? {c_q0[31:16], c_b[15:0]}
                                                   : {c_q0[31:8], c_b[7:0]};
                end
            end
            S_WR2: begin
                c_done  = c_out_free;
                c_dm_we = c_out_free;
                c_dm_wa = r_i1;
                c_dm_wd = c_b[63:32];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_state == S_IDLE || c_done) begin
            n_state = c_accept ? S_EXEC : S_IDLE;
        end
    end

    // Commit of the architectural state and of the result register.
    always_comb begin
        n_pc        = r_pc;
        n_n         = r_n;
        n_z         = r_z;
        n_halt      = r_halt;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_out.ready;
        c_rf_we     = 1'b0;
        if (c_done) begin
            n_out_valid = 1'b1;
            n_res       = '0;
            if (r_halt) begin
                n_res.next_pc = r_pc;
                n_res.halted  = 1'b1;
            end else begin
                if (r_ins == HLT_WORD || c_err) begin
                    n_halt = 1'b1;
                end
                n_pc = c_err ? r_pc : c_npc;
                if (c_setf) begin
                    n_n = c_val[63];
                    n_z = c_val == 64'd0;
                end
                if (c_wr && c_rd != A8X_ZERO_REG) begin
                    c_rf_we             = 1'b1;
                    n_res.reg_written   = 1'b1;
                    n_res.written_reg   = c_rd;
                    n_res.written_value = c_val;
                end
                n_res.next_pc      = n_pc;
                n_res.halted       = n_halt;
                n_res.unrecognized = c_err;
            end
            n_res.flag_neg  = n_n;
            n_res.flag_zero = n_z;
        end
        if (i_cfg_we) begin
            n_pc = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= A8X_START_PC;
            r_n         <= 1'b0;
            r_z         <= 1'b0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_n         <= n_n;
            r_z         <= n_z;
            r_halt      <= n_halt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_ins <= i_in.instruction;
        end
        r_i0  <= n_i0;
        r_i1  <= n_i1;
        r_pp0 <= n_pp0;
        r_res <= n_res;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.next_pc       = r_res.next_pc;
    assign o_out.halted        = r_res.halted;
    assign o_out.unrecognized  = r_res.unrecognized;
    assign o_out.reg_written   = r_res.reg_written;
    assign o_out.written_reg   = r_res.written_reg;
    assign o_out.written_value = r_res.written_value;
    assign o_out.flag_neg      = r_res.flag_neg;
    assign o_out.flag_zero     = r_res.flag_zero;

endmodule
